// ===== rtl/barcode_demultiplex_match_defines.svh =====
// Assertion macros for the barcode demultiplexer.
// Used by rtl/barcode_demultiplex_match.sv; expects i_clk and i_rst_n in scope.
`ifndef BARCODE_DEMULTIPLEX_MATCH_DEFINES_SVH
`define BARCODE_DEMULTIPLEX_MATCH_DEFINES_SVH

// Same-cycle implication, off during reset
`define BDM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define BDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bdm_pkg.sv =====
// Shared sizes, codes and the base-call decode for the barcode demultiplexer.
// No dependencies.
package bdm_pkg;

    localparam int NUM_BARCODES    = 16;
    localparam int MAX_BARCODE_LEN = 32;

    localparam int SLOT_W = $clog2(NUM_BARCODES);
    localparam int POS_W  = $clog2(MAX_BARCODE_LEN);
    localparam int ADDR_W = SLOT_W + POS_W;
    localparam int CNT_W  = $clog2(NUM_BARCODES + 1);
    localparam int RPOS_W = $clog2(MAX_BARCODE_LEN + 1);
    localparam int MEM_DEPTH = NUM_BARCODES * MAX_BARCODE_LEN;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 4;
    localparam int STAT_W  = 2;
    localparam int CFG_I_W = 3;
    localparam int CFG_D_W = 6;
    localparam int MIS_W   = 6;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EMPTY = 2'd2;

    // Result status
    localparam logic [STAT_W-1:0] ST_MATCH    = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDET    = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_I_W-1:0] CFG_BARCODE_COUNT  = 3'd0;
    localparam logic [CFG_I_W-1:0] CFG_FRAGMENT_COUNT = 3'd1;
    localparam logic [CFG_I_W-1:0] CFG_FIRST_LEN      = 3'd2;
    localparam logic [CFG_I_W-1:0] CFG_SECOND_LEN     = 3'd3;
    localparam logic [CFG_I_W-1:0] CFG_FIRST_ERRORS   = 3'd4;
    localparam logic [CFG_I_W-1:0] CFG_SECOND_ERRORS  = 3'd5;

    localparam logic [CHAR_W-1:0] ZERO_QUALITY_LIMIT = 8'd4;
    localparam logic [MIS_W-1:0]  MIS_MAX            = 6'd63;

    // Turn a stored call into its ASCII base
    function automatic logic [CHAR_W-1:0] base_call(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] c;
        case (b[1:0])
            2'd0:    c = 8'h41; // A
            2'd1:    c = 8'h43; // C
            2'd2:    c = 8'h47; // G
            default: c = 8'h54; // T
        endcase
        if (b < ZERO_QUALITY_LIMIT) begin
            c = 8'h4E; // N
        end
        return c;
    endfunction

endpackage

// ===== rtl/barcode_demultiplex_match.sv =====
// Barcode demultiplexer: one shared compare walks the n searched barcodes for every base.
// A load is written to the table at its transfer; a base with no overflow pending holds
// the input through the prepare, scan and finish states, so no new item is taken meanwhile.
// A final base or an empty read waits in the done state until the output register is free.
// Synchronous active-low reset restores the register defaults and clears the read state;
// the table is not reset. Depends on bdm_pkg and barcode_demultiplex_match_defines.svh.
`include "barcode_demultiplex_match_defines.svh"

module barcode_demultiplex_match (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bdm_pkg::CFG_I_W-1:0]   i_cfg_index,
    input  logic [bdm_pkg::CFG_D_W-1:0]   i_cfg_data,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bdm_pkg::CMD_W-1:0]     i_command,
    input  logic [3:0]                    i_table_slot,
    input  logic [4:0]                    i_table_position,
    input  logic [7:0]                    i_table_char,
    input  logic [7:0]                    i_read_byte,
    input  logic                          i_last_base,
    // results
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bdm_pkg::IDX_W-1:0]     o_barcode_index,
    output logic [bdm_pkg::STAT_W-1:0]    o_match_status
);
    import bdm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_FIN,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [4:0]       r_bc_cnt;
    logic [1:0]       r_frag_cnt;
    logic [5:0]       r_len0;
    logic [5:0]       r_len1;
    logic [5:0]       r_err0;
    logic [5:0]       r_err1;

    // read state
    logic             r_failed [NUM_BARCODES];
    logic [MIS_W-1:0] r_mis    [NUM_BARCODES];
    logic [RPOS_W-1:0] r_pos;
    logic [1:0]       r_frag;
    logic [5:0]       r_off;
    logic             r_overflow;

    // per-base work
    logic [CHAR_W-1:0] r_call;
    logic             r_last;
    logic             r_compare;
    logic [5:0]       r_allow;
    logic [CNT_W-1:0] r_idx;
    logic             r_proc_vld;
    logic [SLOT_W-1:0] r_proc_idx;
    logic             r_found;
    logic [SLOT_W-1:0] r_first;
    logic [CHAR_W-1:0] r_rd;

    // result
    logic [IDX_W-1:0]  r_res_idx;
    logic [STAT_W-1:0] r_res_st;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [STAT_W-1:0] r_out_st;

    // table memory
    logic [CHAR_W-1:0] r_table [MEM_DEPTH];

    logic             in_acc;
    logic [1:0]       nfrag;
    logic [CNT_W-1:0] nbc;
    logic [5:0]       cur_len;
    logic             adv;
    logic [1:0]       n_frag;
    logic [5:0]       n_off;
    logic [5:0]       n_len;
    logic             ovf;
    logic             issue_ok;
    logic             scan_done;
    logic             f_old;
    logic [MIS_W-1:0] cnt_old;
    logic             mism;
    logic [MIS_W-1:0] n_cnt;
    logic             n_fail;
    logic             n_overflow;

    assign in_acc      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_barcode_index = r_out_idx;
    assign o_match_status  = r_out_st;

    // Fragment bookkeeping and one scan step
    always_comb begin
        nfrag   = r_frag_cnt[1] ? 2'd2 : 2'd1;
        nbc     = (r_bc_cnt > 5'(NUM_BARCODES)) ? CNT_W'(NUM_BARCODES) : CNT_W'(r_bc_cnt);
        cur_len = (r_frag == 2'd0) ? r_len0 : r_len1;
        adv     = (r_frag < nfrag) && (r_off >= cur_len);
        n_frag  = adv ? r_frag + 2'd1 : r_frag;
        n_off   = adv ? 6'd0 : r_off;
        n_len   = (n_frag == 2'd0) ? r_len0 : r_len1;
        ovf     = (n_frag >= nfrag) || (n_off >= n_len)
                  || (r_pos >= RPOS_W'(MAX_BARCODE_LEN));

        issue_ok  = (r_idx < nbc);
        scan_done = !issue_ok && !r_proc_vld;

        f_old   = r_failed[r_proc_idx];
        cnt_old = r_mis[r_proc_idx];
        mism    = r_compare && !f_old && (r_rd != r_call);
        n_cnt   = (mism && (cnt_old != MIS_MAX)) ? cnt_old + 6'd1 : cnt_old;
        n_fail  = f_old || (mism && (n_cnt > r_allow));

        n_overflow = r_compare ? r_overflow : r_found;
    end

    // Table write on load transfers, registered read during the scan
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_command == CMD_LOAD)) begin
            r_table[{i_table_slot, i_table_position}] <= i_table_char;
        end
        if (r_state == S_SCAN) begin
            r_rd <= r_table[{r_idx[SLOT_W-1:0], r_pos[POS_W-1:0]}];
        end
    end

    // Sequencer, read state, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bc_cnt    <= 5'd1;
            r_frag_cnt  <= 2'd1;
            r_len0      <= 6'd8;
            r_len1      <= 6'd0;
            r_err0      <= 6'd1;
            r_err1      <= 6'd1;
            for (int b = 0; b < NUM_BARCODES; b++) begin
                r_failed[b] <= 1'b0;
                r_mis[b]    <= '0;
            end
            r_pos       <= '0;
            r_frag      <= '0;
            r_off       <= '0;
            r_overflow  <= 1'b0;
            r_idx       <= '0;
            r_proc_vld  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_BARCODE_COUNT:  r_bc_cnt   <= i_cfg_data[4:0];
                    CFG_FRAGMENT_COUNT: r_frag_cnt <= i_cfg_data[1:0];
                    CFG_FIRST_LEN:      r_len0     <= i_cfg_data;
                    CFG_SECOND_LEN:     r_len1     <= i_cfg_data;
                    CFG_FIRST_ERRORS:   r_err0     <= i_cfg_data;
                    CFG_SECOND_ERRORS:  r_err1     <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the result once transferred, unless a new one replaces it
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_command)
                            CMD_READ: begin
                                r_call <= base_call(i_read_byte);
                                r_last <= i_last_base;
                                if (r_overflow) begin
                                    if (i_last_base) begin
                                        r_res_idx <= '0;
                                        r_res_st  <= ST_TOO_LONG;
                                        for (int b = 0; b < NUM_BARCODES; b++) begin
                                            r_failed[b] <= 1'b0;
                                            r_mis[b]    <= '0;
                                        end
                                        r_pos      <= '0;
                                        r_frag     <= '0;
                                        r_off      <= '0;
                                        r_overflow <= 1'b0;
                                        r_state    <= S_DONE;
                                    end
                                end else begin
                                    r_state <= S_PREP;
                                end
                            end
                            CMD_EMPTY: begin
                                r_res_idx <= '0;
                                r_res_st  <= ST_UNDET;
                                for (int b = 0; b < NUM_BARCODES; b++) begin
                                    r_failed[b] <= 1'b0;
                                    r_mis[b]    <= '0;
                                end
                                r_pos      <= '0;
                                r_frag     <= '0;
                                r_off      <= '0;
                                r_overflow <= 1'b0;
                                r_state    <= S_DONE;
                            end
                            default: ;
                        endcase
                    end
                end

                // advance the fragment and decide between compare and overflow check
                S_PREP: begin
                    r_frag <= n_frag;
                    r_off  <= n_off;
                    if (adv) begin
                        for (int b = 0; b < NUM_BARCODES; b++) begin
                            r_mis[b] <= '0;
                        end
                    end
                    r_compare  <= !ovf;
                    r_allow    <= (n_frag == 2'd0) ? r_err0 : r_err1;
                    r_idx      <= '0;
                    r_proc_vld <= 1'b0;
                    r_found    <= 1'b0;
                    r_first    <= '0;
                    r_state    <= S_SCAN;
                end

                // issue one table read and update one barcode per cycle
                S_SCAN: begin
                    if (issue_ok) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    r_proc_vld <= issue_ok;
                    r_proc_idx <= r_idx[SLOT_W-1:0];
                    if (r_proc_vld) begin
                        r_mis[r_proc_idx]    <= n_cnt;
                        r_failed[r_proc_idx] <= n_fail;
                        if (!n_fail && !r_found) begin
                            r_found <= 1'b1;
                            r_first <= r_proc_idx;
                        end
                    end
                    if (scan_done) begin
                        r_state <= S_FIN;
                    end
                end

                // close the base and report on the last one
                S_FIN: begin
                    if (r_last) begin
                        if (n_overflow) begin
                            r_res_idx <= '0;
                            r_res_st  <= ST_TOO_LONG;
                        end else if (r_found) begin
                            r_res_idx <= IDX_W'(r_first);
                            r_res_st  <= ST_MATCH;
                        end else begin
                            r_res_idx <= '0;
                            r_res_st  <= ST_UNDET;
                        end
                        for (int b = 0; b < NUM_BARCODES; b++) begin
                            r_failed[b] <= 1'b0;
                            r_mis[b]    <= '0;
                        end
                        r_pos      <= '0;
                        r_frag     <= '0;
                        r_off      <= '0;
                        r_overflow <= 1'b0;
                        r_state    <= S_DONE;
                    end else begin
                        if (r_compare) begin
                            r_off <= r_off + 6'd1;
                            r_pos <= r_pos + RPOS_W'(1);
                        end else if (r_found) begin
                            r_overflow <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end

                // hold until the output register is free
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_res_idx;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BDM_ASSERT_NOW(a_idx_zero, o_valid && (o_match_status != ST_MATCH), o_barcode_index == '0, "index must be zero unless matched")
    `BDM_ASSERT_NOW(a_scan_bound, r_state == S_SCAN, r_idx <= CNT_W'(NUM_BARCODES), "scan index past barcode count")
    `BDM_ASSERT_NOW(a_pos_bound, 1'b1, r_pos <= RPOS_W'(MAX_BARCODE_LEN), "read position past barcode length")
    `BDM_ASSERT_NOW(a_done_clear, r_state == S_DONE, (r_pos == '0) && !r_overflow, "read state not cleared before result")
    `BDM_ASSERT_NEXT(a_cmp_no_ovf, r_state == S_PREP && !ovf, r_compare && !r_overflow, "compare started with overflow pending")

endmodule

// ===== test/barcode_demultiplex_match_test.sv =====
// Self-checking testbench for barcode_demultiplex_match: loads the barcode table, streams reads
// under many register settings and compares every result against an in-bench predictor.
// Depends on bdm_pkg and the barcode_demultiplex_match RTL.
module barcode_demultiplex_match_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdm_pkg::*;

    localparam logic [CMD_W-1:0]   CMD_UNUSED   = 2'd3;
    localparam logic [CFG_I_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_I_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int MAX_FRAGS     = 2;
    localparam int SETTLE_CYCLES = 32;

    localparam logic [CHAR_W-1:0] CHAR_A = "A";
    localparam logic [CHAR_W-1:0] CHAR_C = "C";
    localparam logic [CHAR_W-1:0] CHAR_G = "G";
    localparam logic [CHAR_W-1:0] CHAR_T = "T";
    localparam logic [CHAR_W-1:0] CHAR_N = "N";

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [STAT_W-1:0] status;
    } t_match;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_I_W-1:0]   i_cfg_index;
    logic [CFG_D_W-1:0]   i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [CMD_W-1:0]     i_command;
    logic [3:0]           i_table_slot;
    logic [4:0]           i_table_position;
    logic [7:0]           i_table_char;
    logic [7:0]           i_read_byte;
    logic                 i_last_base;
    logic                 o_valid;
    logic                 i_ready;
    logic [IDX_W-1:0]     o_barcode_index;
    logic [STAT_W-1:0]    o_match_status;

    // Predictor copy of the table, the per-read scan state and the registers
    logic [CHAR_W-1:0] tbl_bases [NUM_BARCODES][MAX_BARCODE_LEN];
    bit                bc_failed [NUM_BARCODES];
    logic [MIS_W-1:0]  frag_misses [NUM_BARCODES];
    logic [5:0]        read_pos;
    logic [1:0]        frag_idx;
    logic [5:0]        frag_pos;
    bit                read_too_long;
    logic [4:0]        cfg_barcodes;
    logic [1:0]        cfg_fragments;
    logic [5:0]        cfg_len [2];
    logic [5:0]        cfg_allow [2];

    t_match expected_matches [$];
    int     error_count;
    int     items_counted;
    bit     sender_gaps;
    int     hold_request_cycles;
    bit     results_on_hold;

    barcode_demultiplex_match uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_table_slot     (i_table_slot),
        .i_table_position (i_table_position),
        .i_table_char     (i_table_char),
        .i_read_byte      (i_read_byte),
        .i_last_base      (i_last_base),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_barcode_index  (o_barcode_index),
        .o_match_status   (o_match_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int searched_barcodes();
        return (cfg_barcodes > NUM_BARCODES) ? NUM_BARCODES : int'(cfg_barcodes);
    endfunction

    function automatic int used_fragments();
        int n;
        n = int'(cfg_fragments);
        if (n == 0) n = 1;
        if (n > MAX_FRAGS) n = MAX_FRAGS;
        return n;
    endfunction

    function automatic logic [5:0] frag_length(input int f);
        return (f == 0) ? cfg_len[0] : cfg_len[1];
    endfunction

    // Decode a stored call: zero quality is N, else the low bits pick the base
    function automatic logic [CHAR_W-1:0] call_of(input logic [7:0] b);
        if (b < ZERO_QUALITY_LIMIT) return CHAR_N;
        case (b[1:0])
            2'd0:    return CHAR_A;
            2'd1:    return CHAR_C;
            2'd2:    return CHAR_G;
            default: return CHAR_T;
        endcase
    endfunction

    function automatic void clear_read_state();
        for (int b = 0; b < NUM_BARCODES; b++) begin
            bc_failed[b] = 1'b0;
            frag_misses[b] = '0;
        end
        read_pos = '0;
        frag_idx = '0;
        frag_pos = '0;
        read_too_long = 1'b0;
    endfunction

    function automatic void note_config(input logic [CFG_I_W-1:0] idx,
                                        input logic [CFG_D_W-1:0] data);
        case (idx)
            CFG_BARCODE_COUNT:  cfg_barcodes = data[4:0];
            CFG_FRAGMENT_COUNT: cfg_fragments = data[1:0];
            CFG_FIRST_LEN:      cfg_len[0] = data;
            CFG_SECOND_LEN:     cfg_len[1] = data;
            CFG_FIRST_ERRORS:   cfg_allow[0] = data;
            CFG_SECOND_ERRORS:  cfg_allow[1] = data;
            default: ;
        endcase
    endfunction

    // Score one base against every barcode still in the running
    function automatic void take_call(input logic [7:0] b);
        int               nf;
        int               nb;
        logic [CHAR_W-1:0] c;
        logic [5:0]       allow;
        nf = used_fragments();
        nb = searched_barcodes();
        c = call_of(b);
        if (read_too_long) return;
        // advance to the next fragment once this one is used up
        if (frag_idx < nf && frag_pos >= frag_length(int'(frag_idx))) begin
            frag_pos = '0;
            frag_idx = frag_idx + 2'd1;
            for (int k = 0; k < NUM_BARCODES; k++) frag_misses[k] = '0;
        end
        // no room left: flag overflow only while some barcode survives
        if (frag_idx >= nf || frag_pos >= frag_length(int'(frag_idx))
            || read_pos >= MAX_BARCODE_LEN) begin
            for (int k = 0; k < nb; k++) begin
                if (!bc_failed[k]) read_too_long = 1'b1;
            end
            return;
        end
        allow = (frag_idx == 0) ? cfg_allow[0] : cfg_allow[1];
        for (int k = 0; k < nb; k++) begin
            if (!bc_failed[k] && tbl_bases[k][read_pos[4:0]] != c) begin
                if (frag_misses[k] < MIS_MAX) frag_misses[k] = frag_misses[k] + 6'd1;
                if (frag_misses[k] > allow) bc_failed[k] = 1'b1;
            end
        end
        frag_pos = frag_pos + 6'd1;
        read_pos = read_pos + 6'd1;
    endfunction

    function automatic void predict_match(input logic [CMD_W-1:0] cmd, input logic [3:0] slot,
                                          input logic [4:0] pos, input logic [7:0] ch,
                                          input logic [7:0] rb, input logic last);
        t_match m;
        int     nb;
        m.index = '0;
        m.status = ST_UNDET;
        nb = searched_barcodes();
        case (cmd)
            CMD_LOAD: tbl_bases[slot][pos] = ch;
            CMD_READ: begin
                take_call(rb);
                if (last) begin
                    if (read_too_long) begin
                        m.status = ST_TOO_LONG;
                    end else begin
                        for (int k = 0; k < nb; k++) begin
                            if (!bc_failed[k] && m.status == ST_UNDET) begin
                                m.index = IDX_W'(k);
                                m.status = ST_MATCH;
                            end
                        end
                    end
                    expected_matches = {expected_matches, m};
                    clear_read_state();
                end
            end
            CMD_EMPTY: begin
                expected_matches = {expected_matches, m};
                clear_read_state();
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    // Mostly back to back, sometimes short gaps, rarely long ones
    function automatic int idle_cycles(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item and hold it until the transfer; leaves valid high for the caller
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [3:0] slot,
                             input logic [4:0] pos, input logic [7:0] ch,
                             input logic [7:0] rb, input logic last);
        int gap;
        gap = idle_cycles(sender_gaps);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_command        <= cmd;
        i_table_slot     <= slot;
        i_table_position <= pos;
        i_table_char     <= ch;
        i_read_byte      <= rb;
        i_last_base      <= last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_match(cmd, slot, pos, ch, rb, last);
        if (cmd != CMD_UNUSED) items_counted++;
        @(negedge i_clk);
    endtask

    task automatic send_base(input logic [7:0] rb, input logic last);
        send_item(CMD_READ, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)), rb, last);
    endtask

    task automatic send_other(input logic [CMD_W-1:0] cmd);
        send_item(cmd, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    // Table character: mostly bases, some copied from a lower slot to make near twins
    function automatic logic [CHAR_W-1:0] pick_char(input int slot, input int pos);
        int r;
        r = $urandom_range(0, 99);
        if (r < 25 && slot > 0) return tbl_bases[$urandom_range(0, slot - 1)][pos];
        if (r < 85) return call_of(8'($urandom_range(4, 7)));
        if (r < 93) return CHAR_N;
        return 8'($urandom_range(0, 255));
    endfunction

    // A stored call that decodes to the given base or N; any other character gets a random byte
    function automatic logic [7:0] byte_for(input logic [CHAR_W-1:0] c);
        logic [5:0] q;
        q = 6'($urandom_range(1, 63));
        case (c)
            CHAR_A:  return {q, 2'd0};
            CHAR_C:  return {q, 2'd1};
            CHAR_G:  return {q, 2'd2};
            CHAR_T:  return {q, 2'd3};
            CHAR_N:  return 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Stream a read modeled on one barcode, with random base errors
    task automatic send_read(input int target, input int miss_pct, input int length,
                             input bit finish);
        logic [7:0] rb;
        for (int i = 0; i < length; i++) begin
            if (i >= MAX_BARCODE_LEN || $urandom_range(0, 99) < miss_pct)
                rb = 8'($urandom_range(0, 255));
            else
                rb = byte_for(tbl_bases[target][i]);
            send_base(rb, finish && i == length - 1);
        end
    endtask

    task automatic random_load();
        int s;
        int p;
        s = $urandom_range(0, NUM_BARCODES - 1);
        p = $urandom_range(0, MAX_BARCODE_LEN - 1);
        send_item(CMD_LOAD, 4'(s), 5'(p), pick_char(s, p), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    // Drop valid, drain all results, then let any trailing work finish
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_matches.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_I_W-1:0] idx, input logic [CFG_D_W-1:0] data,
                                  input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        note_config(idx, data);
        @(negedge i_clk);
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input int count, input int frags, input int len0,
                                  input int len1, input int err0, input int err1,
                                  input bit with_spare);
        write_register(CFG_BARCODE_COUNT, 6'(count), 1'b1);
        write_register(CFG_FRAGMENT_COUNT, 6'(frags), 1'b1);
        write_register(CFG_FIRST_LEN, 6'(len0), 1'b1);
        write_register(CFG_SECOND_LEN, 6'(len1), 1'b1);
        write_register(CFG_FIRST_ERRORS, 6'(err0), 1'b1);
        write_register(CFG_SECOND_ERRORS, 6'(err1), with_spare);
        if (with_spare) begin
            write_register(CFG_SPARE_LO, 6'($urandom_range(0, 63)), 1'b1);
            write_register(CFG_SPARE_HI, 6'($urandom_range(0, 63)), 1'b0);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Fill every table entry so no read ever touches an unwritten one
    task automatic test_table_fill();
        for (int s = 0; s < NUM_BARCODES; s++) begin
            for (int p = 0; p < MAX_BARCODE_LEN; p++) begin
                send_item(CMD_LOAD, 4'(s), 5'(p), pick_char(s, p), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
        end
        wait_idle();
    endtask

    task automatic test_directed_cases();
        apply_settings(16, 2, 2, 2, 0, 0, 1'b1);
        send_item(CMD_LOAD, 4'd15, 5'd31, 8'h00, 8'hFF, 1'b1);
        send_item(CMD_LOAD, 4'd0, 5'd31, 8'hFF, 8'h00, 1'b0);
        send_other(CMD_EMPTY);
        send_other(CMD_UNUSED);
        // exact dual-index match
        send_read(5, 0, 4, 1'b1);
        // quality extremes: zero, full, top of zero quality, lowest called
        send_base(8'h00, 1'b0);
        send_base(8'hFF, 1'b0);
        send_base(8'h03, 1'b0);
        send_base(8'h04, 1'b1);
        // one base past the fragments
        send_read(3, 0, 5, 1'b1);
        // empty read abandons a partial read
        send_read(1, 0, 2, 1'b0);
        send_other(CMD_EMPTY);
        wait_idle();
    endtask

    // Hold results off long enough for the block to fill and stall its input
    task automatic test_result_backpressure();
        apply_settings(16, 1, 1, 0, 0, 0, 1'b0);
        sender_gaps = 1'b0;
        hold_request_cycles = 400;
        wait (results_on_hold);
        repeat (40) send_read($urandom_range(0, NUM_BARCODES - 1), 10, 1, 1'b1);
        wait_idle();
    endtask

    // One register setting, then a mix of well-formed, short, long and broken reads, loads and unused commands
    task automatic run_read_phase(input int count, input int frags, input int len0,
                                  input int len1, input int err0, input int err1,
                                  input int budget);
        int nf;
        int nb;
        int full;
        int first;
        int kind;
        int target;
        int miss;
        apply_settings(count, frags, len0, len1, err0, err1, 1'b0);
        sender_gaps = ($urandom_range(0, 3) != 0);
        nf = (frags == 0) ? 1 : ((frags > MAX_FRAGS) ? MAX_FRAGS : frags);
        nb = (count > NUM_BARCODES) ? NUM_BARCODES : ((count == 0) ? 1 : count);
        full = len0 + ((nf == 2) ? len1 : 0);
        if (full > MAX_BARCODE_LEN) full = MAX_BARCODE_LEN;
        if (full == 0) full = 1;
        first = items_counted;
        while (items_counted - first < budget) begin
            kind = $urandom_range(0, 99);
            miss = $urandom_range(0, 3) * 6;
            if ($urandom_range(0, 4) != 0)
                target = $urandom_range(0, nb - 1);
            else
                target = $urandom_range(0, NUM_BARCODES - 1);
            if (kind < 70) begin
                send_read(target, miss, full, 1'b1);
            end else if (kind < 80) begin
                send_read(target, miss, $urandom_range(1, full), 1'b1);
            end else if (kind < 88) begin
                send_read(target, miss, full + $urandom_range(1, 3), 1'b1);
            end else if (kind < 92) begin
                send_read(target, 0, $urandom_range(0, full), 1'b0);
                send_other(CMD_EMPTY);
            end else if (kind < 95) begin
                // unfinished read runs into the next one
                send_read(target, 0, $urandom_range(1, full), 1'b0);
            end else if (kind < 98) begin
                repeat ($urandom_range(1, 4)) random_load();
            end else begin
                send_other(CMD_UNUSED);
            end
        end
        wait_idle();
    endtask

    task automatic test_setting_sweep();
        run_read_phase(16, 1, 4, 0, 1, 1, 70);
        run_read_phase(1, 2, 3, 3, 0, 0, 70);
        run_read_phase(0, 1, 4, 0, 1, 1, 50);
        run_read_phase(31, 3, 2, 5, 1, 2, 70);
        run_read_phase(16, 0, 0, 6, 0, 0, 50);
        run_read_phase(16, 2, 0, 4, 0, 1, 60);
        run_read_phase(8, 2, 32, 32, 32, 32, 100);
        run_read_phase(16, 2, 16, 16, 3, 0, 100);
        run_read_phase(4, 1, 63, 63, 63, 63, 80);
    endtask

    // Mostly small lengths and allowances, now and then an extreme
    function automatic int pick_setting(input int common_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) return $urandom_range(0, common_max);
        if (r < 94) return 32;
        return 63;
    endfunction

    task automatic test_random_settings();
        for (int k = 0; k < 6; k++) begin
            run_read_phase(($urandom_range(0, 3) == 0) ? $urandom_range(17, 31)
                                                       : $urandom_range(0, 16),
                           $urandom_range(0, 3), pick_setting(6), pick_setting(6),
                           pick_setting(2), pick_setting(2), 60);
        end
    endtask

    // ---------------------------------------------------------------- processes

    // Result side: random stalls, long ready stretches, and a long hold on request
    initial begin : result_receiver
        int run;
        int stall;
        i_ready <= 1'b0;
        results_on_hold = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request_cycles > 0) begin
                stall = hold_request_cycles;
                hold_request_cycles = 0;
                results_on_hold = 1'b1;
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                results_on_hold = 1'b0;
            end
            i_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
            repeat (run) @(negedge i_clk);
            stall = idle_cycles(1'b1);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    initial begin : result_checker
        t_match want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
                if (expected_matches.size() == 0) begin
                    $error("unexpected result: barcode_index %0d match_status %0d",
                           o_barcode_index, o_match_status);
                    error_count++;
                end else begin
                    want = expected_matches.pop_front();
                    if (o_barcode_index !== want.index) begin
                        $error("barcode_index: expected %0d, got %0d", want.index,
                               o_barcode_index);
                        error_count++;
                    end
                    if (o_match_status !== want.status) begin
                        $error("match_status: expected %0d, got %0d", want.status,
                               o_match_status);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("** barcode_demultiplex_match: FAILED **");
        $finish;
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_command        <= CMD_LOAD;
        i_table_slot     <= '0;
        i_table_position <= '0;
        i_table_char     <= '0;
        i_read_byte      <= '0;
        i_last_base      <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_data       <= '0;
        error_count = 0;
        items_counted = 0;
        sender_gaps = 1'b1;
        hold_request_cycles = 0;
        clear_read_state();
        // register defaults after reset
        cfg_barcodes  = 5'd1;
        cfg_fragments = 2'd1;
        cfg_len[0]    = 6'd8;
        cfg_len[1]    = 6'd0;
        cfg_allow[0]  = 6'd1;
        cfg_allow[1]  = 6'd1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_table_fill();
        test_directed_cases();
        test_result_backpressure();
        test_setting_sweep();
        test_random_settings();
        wait_idle();

        if (error_count == 0) begin
            $display("** barcode_demultiplex_match: PASSED **");
        end else begin
            $display("** barcode_demultiplex_match: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bdm_pkg.sv
rtl/barcode_demultiplex_match.sv
test/barcode_demultiplex_match_test.sv
